>>> src/wsrx_pkg.sv
package wsrx_pkg;

    typedef enum logic [2:0] {
        PH_HDR0,
        PH_HDR1,
        PH_EXTLEN,
        PH_MASK,
        PH_PAYLOAD
    } phase_t;

    localparam logic [3:0] ST_OK        = 4'd0;
    localparam logic [3:0] ST_RSV       = 4'd1;
    localparam logic [3:0] ST_RSV1      = 4'd2;
    localparam logic [3:0] ST_OPCODE    = 4'd3;
    localparam logic [3:0] ST_MASK      = 4'd4;
    localparam logic [3:0] ST_STRAY     = 4'd5;
    localparam logic [3:0] ST_INTERLEAV = 4'd6;
    localparam logic [3:0] ST_UTF8      = 4'd7;
    localparam logic [3:0] ST_CLOSE     = 4'd8;

    localparam logic [3:0] OP_CONT  = 4'd0;
    localparam logic [3:0] OP_TEXT  = 4'd1;
    localparam logic [3:0] OP_BIN   = 4'd2;
    localparam logic [3:0] OP_CLOSE = 4'd8;
    localparam logic [3:0] OP_PING  = 4'd9;
    localparam logic [3:0] OP_PONG  = 4'd10;

    localparam logic [15:0] CODE_NORMAL   = 16'd1000;
    localparam logic [15:0] CODE_PROTOCOL = 16'd1002;
    localparam logic [15:0] CODE_BAD_DATA = 16'd1007;

    localparam int REG_ROLE    = 0;
    localparam int REG_DEFLATE = 1;

    // one result item
    typedef struct packed {
        logic [7:0]  payload_byte;
        logic        byte_valid;
        logic [3:0]  frame_opcode;
        logic        message_type;
        logic        compressed;
        logic        frame_end;
        logic        message_end;
        logic [3:0]  status;
        logic [15:0] close_code;
    } result_t;

    // classified byte passed from front to back
    typedef struct packed {
        logic        hdr_err;     // header failed its checks
        logic [3:0]  err_status;
        logic        payload;     // byte is a payload byte
        logic        empty_end;   // last header byte of an empty frame
        logic        last;        // last payload byte
        logic [7:0]  pb;          // unmasked byte
        logic [7:0]  flags;
        logic        new_msg;     // first data frame header, reset utf8
    } cls_t;

    function automatic logic close_code_ok(input logic [15:0] c);
        logic ok;
        begin
            if (c < 16'd1000) ok = 1'b0;
            else if (c <= 16'd1003) ok = 1'b1;
            else if (c <= 16'd1006) ok = 1'b0;
            else if (c <= 16'd1011) ok = 1'b1;
            else if (c <= 16'd2999) ok = 1'b0;
            else ok = (c <= 16'd4999);
            return ok;
        end
    endfunction

endpackage

>>> src/websocket_rx_deframer_top.sv
// a result passes the queue and then the result register after its byte is
// accepted, and waits longer while earlier requests sit in the queue
// throughput: one byte per cycle while the queue has room, set by the header
// parser and a four-entry queue, three used, decoupling it from the result register
// reset: asynchronous active low; parser returns to the first header byte,
// configuration clears, and the block reopens after a close or an error
module websocket_rx_deframer_top
    import wsrx_pkg::*;
#(
    parameter int QDEPTH = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic        cfg_wdata,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  payload_byte,
    output logic        byte_valid,
    output logic [3:0]  frame_opcode,
    output logic        message_type,
    output logic        compressed,
    output logic        frame_end,
    output logic        message_end,
    output logic [3:0]  status,
    output logic [15:0] close_code
);

    logic    role_reg, deflate_reg;
    logic    push, pop, not_empty, room;
    cls_t    wdata, rdata;
    result_t res;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            role_reg <= 1'b0;
            deflate_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            if (cfg_index == 1'(REG_ROLE)) role_reg <= cfg_wdata;
            if (cfg_index == 1'(REG_DEFLATE)) deflate_reg <= cfg_wdata;
        end
    end

    assign in_stall = !room;

    wsrx_front u_front (
        .clk(clk), .rst_n(rst_n),
        .role_is_client(role_reg), .deflate_enabled(deflate_reg),
        .in_fire(in_valid), .rx_byte(rx_byte), .halt(!room),
        .push(push), .push_data(wdata)
    );

    wsrx_queue #(.DEPTH(QDEPTH)) u_queue (
        .clk(clk), .rst_n(rst_n), .push(push), .wdata(wdata),
        .pop(pop), .not_empty(not_empty), .room(room), .rdata(rdata)
    );

    wsrx_back u_back (
        .clk(clk), .rst_n(rst_n), .not_empty(not_empty), .rdata(rdata),
        .pop(pop), .out_valid(out_valid), .out_stall(out_stall), .out_data(res)
    );

    assign payload_byte = res.payload_byte;
    assign byte_valid = res.byte_valid;
    assign frame_opcode = res.frame_opcode;
    assign message_type = res.message_type;
    assign compressed = res.compressed;
    assign frame_end = res.frame_end;
    assign message_end = res.message_end;
    assign status = res.status;
    assign close_code = res.close_code;

`ifndef ASSERT_OFF
    // close results always carry the frame end mark
    a_close_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_CLOSE |-> frame_end)
        else $error("close without frame end");
    // error results never deliver a byte
    a_err_nobyte: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_OK && status != ST_CLOSE |-> !byte_valid && !frame_end)
        else $error("error result carries data");
    // message end only at a frame end
    a_msg_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && message_end |-> frame_end)
        else $error("message end without frame end");
`endif

endmodule

>>> src/wsrx_front.sv
module wsrx_front
    import wsrx_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       role_is_client,
    input  logic       deflate_enabled,
    input  logic       in_fire,
    input  logic [7:0] rx_byte,
    input  logic       halt,
    output logic       push,
    output cls_t       push_data
);

    phase_t      phase_reg, phase_next;
    logic [2:0]  hcnt_reg, hcnt_next;
    logic [7:0]  flags_reg, flags_next;
    logic [63:0] rlen_reg, rlen_next;
    logic [31:0] key_reg, key_next;
    logic [1:0]  midx_reg, midx_next;
    logic        mpres_reg, mpres_next;
    logic        frag_reg, frag_next;
    logic        stop_reg, stop_next;

    logic [3:0]  op;
    logic        rsv1;
    logic        first_data;
    logic [3:0]  st;
    logic [7:0]  k;
    logic [63:0] len_hdr;
    logic        hdr_done;

    // header checks on the completed header
    always_comb
    begin
        op = flags_reg[3:0];
        rsv1 = flags_reg[6];
        first_data = (op == OP_TEXT) || (op == OP_BIN);
        if (rsv1 && !deflate_enabled) st = ST_RSV;
        else if (rsv1 && !first_data) st = ST_RSV1;
        else if (flags_reg[5:4] != 2'b00) st = ST_RSV;
        else if (!(op <= OP_BIN || (op >= OP_CLOSE && op <= OP_PONG))) st = ST_OPCODE;
        else if (mpres_next == role_is_client) st = ST_MASK;
        else if (op == OP_CONT && !frag_reg) st = ST_STRAY;
        else if (first_data && frag_reg) st = ST_INTERLEAV;
        else st = ST_OK;
    end

    // parse state machine
    always_comb
    begin
        phase_next = phase_reg;
        hcnt_next = hcnt_reg;
        flags_next = flags_reg;
        rlen_next = rlen_reg;
        key_next = key_reg;
        midx_next = midx_reg;
        mpres_next = mpres_reg;
        frag_next = frag_reg;
        stop_next = stop_reg;
        hdr_done = 1'b0;
        len_hdr = rlen_reg;
        push = 1'b0;
        push_data = '0;
        push_data.flags = flags_reg;
        k = mpres_reg ? key_reg[{~midx_reg, 3'b000} +: 8] : 8'h00;
        if (in_fire && !stop_reg && !halt)
        begin
            case (phase_reg)
                PH_HDR0:
                begin
                    flags_next = rx_byte;
                    phase_next = PH_HDR1;
                end
                PH_HDR1:
                begin
                    mpres_next = rx_byte[7];
                    key_next = '0;
                    rlen_next = '0;
                    if (rx_byte[6:0] == 7'd126)
                    begin
                        hcnt_next = 3'd1;
                        phase_next = PH_EXTLEN;
                    end
                    else if (rx_byte[6:0] == 7'd127)
                    begin
                        hcnt_next = 3'd7;
                        phase_next = PH_EXTLEN;
                    end
                    else
                    begin
                        rlen_next = {57'd0, rx_byte[6:0]};
                        len_hdr = rlen_next;
                        if (rx_byte[7])
                        begin
                            hcnt_next = 3'd3;
                            phase_next = PH_MASK;
                        end
                        else
                            hdr_done = 1'b1;
                    end
                end
                PH_EXTLEN:
                begin
                    rlen_next = {rlen_reg[55:0], rx_byte};
                    len_hdr = rlen_next;
                    if (hcnt_reg != 3'd0)
                        hcnt_next = hcnt_reg - 3'd1;
                    else if (mpres_reg)
                    begin
                        hcnt_next = 3'd3;
                        phase_next = PH_MASK;
                    end
                    else
                        hdr_done = 1'b1;
                end
                PH_MASK:
                begin
                    key_next = {key_reg[23:0], rx_byte};
                    if (hcnt_reg != 3'd0)
                        hcnt_next = hcnt_reg - 3'd1;
                    else
                        hdr_done = 1'b1;
                end
                PH_PAYLOAD:
                begin
                    push = 1'b1;
                    push_data.payload = 1'b1;
                    push_data.pb = rx_byte ^ k;
                    midx_next = midx_reg + 2'd1;
                    rlen_next = rlen_reg - 64'd1;
                    push_data.last = (rlen_reg == 64'd1);
                    if (rlen_reg == 64'd1)
                        phase_next = PH_HDR0;
                end
                default:
                    phase_next = PH_HDR0;
            endcase
            if (hdr_done)
            begin
                if (st != ST_OK)
                begin
                    push = 1'b1;
                    push_data.hdr_err = 1'b1;
                    push_data.err_status = st;
                    stop_next = 1'b1;
                end
                else
                begin
                    if (first_data)
                    begin
                        frag_next = !flags_reg[7];
                        push_data.new_msg = 1'b1;
                    end
                    else if (op == OP_CONT && flags_reg[7])
                        frag_next = 1'b0;
                    midx_next = 2'd0;
                    if (len_hdr == 64'd0)
                    begin
                        push = 1'b1;
                        push_data.empty_end = 1'b1;
                        phase_next = PH_HDR0;
                    end
                    else
                    begin
                        push = push_data.new_msg;
                        phase_next = PH_PAYLOAD;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HDR0;
            hcnt_reg <= '0;
            flags_reg <= '0;
            rlen_reg <= '0;
            key_reg <= '0;
            midx_reg <= '0;
            mpres_reg <= 1'b0;
            frag_reg <= 1'b0;
            stop_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            hcnt_reg <= hcnt_next;
            flags_reg <= flags_next;
            rlen_reg <= rlen_next;
            key_reg <= key_next;
            midx_reg <= midx_next;
            mpres_reg <= mpres_next;
            frag_reg <= frag_next;
            stop_reg <= stop_next;
        end
    end

endmodule

>>> src/wsrx_queue.sv
module wsrx_queue
    import wsrx_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cls_t wdata,
    input  logic pop,
    output logic not_empty,
    output logic room,
    output cls_t rdata
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    cls_t          mem_reg [DEPTH];
    logic [AW-1:0] wp_reg, rp_reg;
    logic [AW:0]   cnt_reg;

    assign not_empty = (cnt_reg != '0);
    assign room = (cnt_reg < (AW + 1)'(DEPTH - 1));
    assign rdata = mem_reg[rp_reg];

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wp_reg] <= wdata;
    end

    // pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= '0;
            rp_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wp_reg <= (wp_reg == AW'(DEPTH - 1)) ? '0 : wp_reg + 1'b1;
            if (pop)
                rp_reg <= (rp_reg == AW'(DEPTH - 1)) ? '0 : rp_reg + 1'b1;
            cnt_reg <= cnt_reg + (AW + 1)'(push) - (AW + 1)'(pop);
        end
    end

endmodule

>>> src/wsrx_back.sv
module wsrx_back
    import wsrx_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    not_empty,
    input  cls_t    rdata,
    output logic    pop,
    output logic    out_valid,
    input  logic    out_stall,
    output result_t out_data
);

    result_t     res_reg, res_next;
    logic        ov_reg, ov_next;
    logic        bin_reg, bin_next;
    logic        cmp_reg, cmp_next;
    logic [3:0]  utf_reg, utf_next;
    logic [15:0] ccode_reg, ccode_next;
    logic [1:0]  ccnt_reg, ccnt_next;
    logic        stop_reg, stop_next;

    logic [3:0]  op;
    logic        data_op;
    logic        utf_on;
    logic        utf_bad;
    logic        fin_end;
    logic        can_take;
    logic [7:0]  b;
    logic [7:0]  lo;
    logic [7:0]  hi;
    logic [15:0] cc;
    logic [1:0]  cn;
    logic [3:0]  un;

    assign out_valid = ov_reg;
    assign out_data = res_reg;
    assign can_take = !ov_reg || !out_stall;
    assign pop = not_empty && can_take;

    always_comb
    begin
        res_next = res_reg;
        ov_next = ov_reg && out_stall;
        bin_next = bin_reg;
        cmp_next = cmp_reg;
        utf_next = utf_reg;
        ccode_next = ccode_reg;
        ccnt_next = ccnt_reg;
        stop_next = stop_reg;
        op = rdata.flags[3:0];
        b = rdata.pb;
        utf_bad = 1'b0;
        un = utf_reg;
        lo = 8'h80;
        hi = 8'hBF;
        cc = ccode_reg;
        cn = ccnt_reg;
        fin_end = 1'b0;
        if (rdata.new_msg)
        begin
            data_op = 1'b1;
            utf_on = (op == OP_TEXT) && !rdata.flags[6];
        end
        else
        begin
            data_op = (op <= OP_BIN);
            utf_on = data_op && !bin_reg && !cmp_reg;
        end
        // streaming utf-8 check
        if (utf_reg == 4'd0)
        begin
            if (b < 8'h80) un = 4'd0;
            else if (b >= 8'hC2 && b <= 8'hDF) un = 4'd1;
            else if (b == 8'hE0) un = 4'd4;
            else if (b == 8'hED) un = 4'd5;
            else if (b >= 8'hE1 && b <= 8'hEF) un = 4'd2;
            else if (b == 8'hF0) un = 4'd6;
            else if (b >= 8'hF1 && b <= 8'hF3) un = 4'd3;
            else if (b == 8'hF4) un = 4'd7;
            else utf_bad = 1'b1;
        end
        else
        begin
            if (utf_reg == 4'd4) lo = 8'hA0;
            else if (utf_reg == 4'd5) hi = 8'h9F;
            else if (utf_reg == 4'd6) lo = 8'h90;
            else if (utf_reg == 4'd7) hi = 8'h8F;
            if (b < lo || b > hi) utf_bad = 1'b1;
            if (utf_reg == 4'd1) un = 4'd0;
            else if (utf_reg == 4'd2 || utf_reg == 4'd4 || utf_reg == 4'd5) un = 4'd1;
            else un = 4'd2;
        end
        if (pop && !stop_reg)
        begin
            res_next = '0;
            res_next.frame_opcode = op;
            if (rdata.hdr_err)
            begin
                ov_next = 1'b1;
                res_next.status = rdata.err_status;
                res_next.close_code = CODE_PROTOCOL;
                stop_next = 1'b1;
                // message tags reflect state before this header
                res_next.message_type = data_op ? bin_reg : 1'b0;
                res_next.compressed = data_op ? cmp_reg : 1'b0;
            end
            else
            begin
                if (rdata.new_msg)
                begin
                    bin_next = (op == OP_BIN);
                    cmp_next = rdata.flags[6];
                    utf_next = 4'd0;
                end
                if (rdata.new_msg || rdata.empty_end)
                begin
                    cc = 16'd0;
                    cn = 2'd0;
                end
                res_next.message_type = data_op ? bin_next : 1'b0;
                res_next.compressed = data_op ? cmp_next : 1'b0;
                if (rdata.payload)
                begin
                    if (op == OP_CLOSE && cn != 2'd2)
                    begin
                        cc = {cc[7:0], b};
                        cn = cn + 2'd1;
                    end
                    if (utf_on && utf_bad)
                    begin
                        ov_next = 1'b1;
                        res_next.status = ST_UTF8;
                        res_next.close_code = CODE_BAD_DATA;
                        stop_next = 1'b1;
                    end
                    else
                    begin
                        if (utf_on)
                            utf_next = un;
                        ov_next = 1'b1;
                        res_next.payload_byte = b;
                        res_next.byte_valid = 1'b1;
                    end
                end
                else if (rdata.empty_end)
                    ov_next = 1'b1;
                ccode_next = cc;
                ccnt_next = cn;
                // frame completion
                if (!stop_next && (rdata.last || rdata.empty_end))
                begin
                    res_next.frame_end = 1'b1;
                    fin_end = data_op && rdata.flags[7];
                    if (fin_end && utf_on && utf_next != 4'd0)
                    begin
                        res_next = '0;
                        res_next.frame_opcode = op;
                        res_next.message_type = bin_next;
                        res_next.compressed = cmp_next;
                        res_next.status = ST_UTF8;
                        res_next.close_code = CODE_BAD_DATA;
                        stop_next = 1'b1;
                    end
                    else if (op == OP_CLOSE)
                    begin
                        res_next.status = ST_CLOSE;
                        if (cn != 2'd2) res_next.close_code = CODE_NORMAL;
                        else if (close_code_ok(cc)) res_next.close_code = cc;
                        else res_next.close_code = CODE_PROTOCOL;
                        stop_next = 1'b1;
                    end
                    else
                        res_next.message_end = fin_end;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ov_reg <= 1'b0;
            bin_reg <= 1'b0;
            cmp_reg <= 1'b0;
            utf_reg <= '0;
            ccode_reg <= '0;
            ccnt_reg <= '0;
            stop_reg <= 1'b0;
        end
        else
        begin
            ov_reg <= ov_next;
            bin_reg <= bin_next;
            cmp_reg <= cmp_next;
            utf_reg <= utf_next;
            ccode_reg <= ccode_next;
            ccnt_reg <= ccnt_next;
            stop_reg <= stop_next;
        end
    end

endmodule

>>> sim/websocket_rx_deframer_checker.sv
module websocket_rx_deframer_checker
    import wsrx_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic        cfg_wdata,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [7:0]  rx_byte,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [7:0]  payload_byte,
    input  logic        byte_valid,
    input  logic [3:0]  frame_opcode,
    input  logic        message_type,
    input  logic        compressed,
    input  logic        frame_end,
    input  logic        message_end,
    input  logic [3:0]  status,
    input  logic [15:0] close_code,
    output int          fail_count,
    output int          pending
);

    // configuration shadow
    logic        role_client;
    logic        deflate_on;

    // parser shadow state
    phase_t      parse_at;
    logic [2:0]  hdr_left;
    logic [7:0]  flags;
    logic [63:0] len_left;
    logic [31:0] key;
    logic [1:0]  key_pos;
    logic        frag_open;
    logic        msg_binary;
    logic        msg_deflated;
    logic [15:0] code_acc;
    logic [1:0]  code_bytes;
    logic [3:0]  utf8_need;
    logic        halted;
    logic        masked;

    result_t     expected_results[$];

    function automatic logic data_frame();
        return flags[3:0] <= OP_BIN;
    endfunction

    function automatic logic text_checked();
        return data_frame() && !msg_binary && !msg_deflated;
    endfunction

    function automatic logic code_allowed(input logic [15:0] c);
        return (c >= 16'd1000 && c <= 16'd1003) || (c >= 16'd1007 && c <= 16'd1011)
            || (c >= 16'd3000 && c <= 16'd4999);
    endfunction

    function automatic result_t make_result(input logic [7:0] pb, input logic v,
                                            input logic fe, input logic me,
                                            input logic [3:0] st, input logic [15:0] code);
        result_t r;
        r.payload_byte = pb;
        r.byte_valid   = v;
        r.frame_opcode = flags[3:0];
        r.message_type = data_frame() ? msg_binary : 1'b0;
        r.compressed   = data_frame() ? msg_deflated : 1'b0;
        r.frame_end    = fe;
        r.message_end  = me;
        r.status       = st;
        r.close_code   = code;
        return r;
    endfunction

    function automatic result_t abort_with(input logic [3:0] st);
        halted = 1'b1;
        return make_result(8'd0, 1'b0, 1'b0, 1'b0, st,
                           (st == ST_UTF8) ? CODE_BAD_DATA : CODE_PROTOCOL);
    endfunction

    // strict utf-8 decoder, returns 0 on a bad byte
    function automatic logic utf8_accept(input logic [7:0] b);
        logic [7:0] lo;
        logic [7:0] hi;
        logic [3:0] nxt;
        lo = 8'h80;
        hi = 8'hBF;
        if (utf8_need == 4'd0)
        begin
            if (b < 8'h80) nxt = 4'd0;
            else if (b >= 8'hC2 && b <= 8'hDF) nxt = 4'd1;
            else if (b == 8'hE0) nxt = 4'd4;
            else if (b == 8'hED) nxt = 4'd5;
            else if (b >= 8'hE1 && b <= 8'hEF) nxt = 4'd2;
            else if (b == 8'hF0) nxt = 4'd6;
            else if (b >= 8'hF1 && b <= 8'hF3) nxt = 4'd3;
            else if (b == 8'hF4) nxt = 4'd7;
            else return 1'b0;
        end
        else
        begin
            if (utf8_need == 4'd4) lo = 8'hA0;
            else if (utf8_need == 4'd5) hi = 8'h9F;
            else if (utf8_need == 4'd6) lo = 8'h90;
            else if (utf8_need == 4'd7) hi = 8'h8F;
            if (b < lo || b > hi) return 1'b0;
            if (utf8_need == 4'd1) nxt = 4'd0;
            else if (utf8_need == 4'd2 || utf8_need == 4'd4 || utf8_need == 4'd5) nxt = 4'd1;
            else nxt = 4'd2;
        end
        utf8_need = nxt;
        return 1'b1;
    endfunction

    // end of a frame always gives one result
    function automatic result_t end_of_frame(input logic [7:0] pb, input logic v);
        logic        me;
        logic [15:0] code;
        me = 1'b0;
        parse_at = PH_HDR0;
        if (data_frame() && flags[7])
        begin
            if (text_checked() && utf8_need != 4'd0) return abort_with(ST_UTF8);
            me = 1'b1;
        end
        if (flags[3:0] == OP_CLOSE)
        begin
            code = CODE_NORMAL;
            if (code_bytes >= 2'd2) code = code_allowed(code_acc) ? code_acc : CODE_PROTOCOL;
            halted = 1'b1;
            return make_result(pb, v, 1'b1, 1'b0, ST_CLOSE, code);
        end
        return make_result(pb, v, 1'b1, me, ST_OK, 16'd0);
    endfunction

    // header checks once the last header byte is in
    task automatic finish_header(output logic got, output result_t r);
        logic [3:0] op;
        logic       rsv1;
        logic       starts_msg;
        logic [3:0] st;
        op = flags[3:0];
        rsv1 = flags[6];
        starts_msg = (op == OP_TEXT || op == OP_BIN);
        st = ST_OK;
        got = 1'b0;
        if (rsv1 && !deflate_on) st = ST_RSV;
        else if (rsv1 && !starts_msg) st = ST_RSV1;
        else if (flags[5:4] != 2'b00) st = ST_RSV;
        else if (!(op <= OP_BIN || (op >= OP_CLOSE && op <= OP_PONG))) st = ST_OPCODE;
        else if (masked == role_client) st = ST_MASK;
        else if (op == OP_CONT && !frag_open) st = ST_STRAY;
        else if (starts_msg && frag_open) st = ST_INTERLEAV;
        if (st != ST_OK)
        begin
            got = 1'b1;
            r = abort_with(st);
            return;
        end
        if (starts_msg)
        begin
            msg_binary = (op == OP_BIN);
            msg_deflated = rsv1;
            frag_open = !flags[7];
            utf8_need = 4'd0;
        end
        else if (op == OP_CONT && flags[7])
        begin
            frag_open = 1'b0;
        end
        key_pos = 2'd0;
        code_bytes = 2'd0;
        code_acc = 16'd0;
        if (len_left == 64'd0)
        begin
            got = 1'b1;
            r = end_of_frame(8'd0, 1'b0);
        end
        else
        begin
            parse_at = PH_PAYLOAD;
        end
    endtask

    // one received byte through the shadow parser
    task automatic parse_byte(input logic [7:0] b, output logic got, output result_t r);
        logic [7:0] k;
        logic [7:0] pb;
        got = 1'b0;
        if (halted) return;
        case (parse_at)
            PH_HDR0:
            begin
                flags = b;
                parse_at = PH_HDR1;
            end
            PH_HDR1:
            begin
                masked = b[7];
                key = 32'd0;
                len_left = 64'd0;
                if (b[6:0] == 7'd126)
                begin
                    hdr_left = 3'd1;
                    parse_at = PH_EXTLEN;
                end
                else if (b[6:0] == 7'd127)
                begin
                    hdr_left = 3'd7;
                    parse_at = PH_EXTLEN;
                end
                else
                begin
                    len_left = {57'd0, b[6:0]};
                    if (masked)
                    begin
                        hdr_left = 3'd3;
                        parse_at = PH_MASK;
                    end
                    else
                    begin
                        finish_header(got, r);
                    end
                end
            end
            PH_EXTLEN:
            begin
                len_left = {len_left[55:0], b};
                if (hdr_left != 3'd0)
                begin
                    hdr_left = hdr_left - 3'd1;
                end
                else if (masked)
                begin
                    hdr_left = 3'd3;
                    parse_at = PH_MASK;
                end
                else
                begin
                    finish_header(got, r);
                end
            end
            PH_MASK:
            begin
                key = {key[23:0], b};
                if (hdr_left != 3'd0) hdr_left = hdr_left - 3'd1;
                else finish_header(got, r);
            end
            default:
            begin
                k = masked ? key[{~key_pos, 3'b000} +: 8] : 8'd0;
                pb = b ^ k;
                key_pos = key_pos + 2'd1;
                len_left = len_left - 64'd1;
                if (flags[3:0] == OP_CLOSE && code_bytes < 2'd2)
                begin
                    code_acc = {code_acc[7:0], pb};
                    code_bytes = code_bytes + 2'd1;
                end
                got = 1'b1;
                if (text_checked() && !utf8_accept(pb)) r = abort_with(ST_UTF8);
                else if (len_left == 64'd0) r = end_of_frame(pb, 1'b1);
                else r = make_result(pb, 1'b1, 1'b0, 1'b0, ST_OK, 16'd0);
            end
        endcase
    endtask

    task automatic compare_field(input string name, input int want, input int seen);
        if (want != seen)
        begin
            fail_count++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, seen);
        end
    endtask

    // watch both channels and the configuration port
    always @(posedge clk or negedge rst_n)
    begin
        logic    got;
        result_t r;
        if (!rst_n)
        begin
            role_client = 1'b0;
            deflate_on = 1'b0;
            parse_at = PH_HDR0;
            hdr_left = 3'd0;
            flags = 8'd0;
            len_left = 64'd0;
            key = 32'd0;
            key_pos = 2'd0;
            frag_open = 1'b0;
            msg_binary = 1'b0;
            msg_deflated = 1'b0;
            code_acc = 16'd0;
            code_bytes = 2'd0;
            utf8_need = 4'd0;
            halted = 1'b0;
            masked = 1'b0;
            expected_results.delete();
            fail_count = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == REG_ROLE[0]) role_client = cfg_wdata;
                else deflate_on = cfg_wdata;
            end
            if (in_valid && !in_stall)
            begin
                parse_byte(rx_byte, got, r);
                if (got) expected_results.push_back(r);
            end
            if (out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: unexpected result, expected none, actual status %0d byte %0d",
                             $time, status, payload_byte);
                end
                else
                begin
                    r = expected_results.pop_front();
                    compare_field("payload_byte", r.payload_byte, payload_byte);
                    compare_field("byte_valid", r.byte_valid, byte_valid);
                    compare_field("frame_opcode", r.frame_opcode, frame_opcode);
                    compare_field("message_type", r.message_type, message_type);
                    compare_field("compressed", r.compressed, compressed);
                    compare_field("frame_end", r.frame_end, frame_end);
                    compare_field("message_end", r.message_end, message_end);
                    compare_field("status", r.status, status);
                    compare_field("close_code", r.close_code, close_code);
                end
            end
        end
        pending = expected_results.size();
    end

endmodule

>>> sim/tb_websocket_rx_deframer_top.sv
module tb_websocket_rx_deframer_top;
    import wsrx_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int BYTE_TARGET = 650;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic        cfg_index = 1'b0;
    logic        cfg_wdata = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  rx_byte = 8'd0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [7:0]  payload_byte;
    logic        byte_valid;
    logic [3:0]  frame_opcode;
    logic        message_type;
    logic        compressed;
    logic        frame_end;
    logic        message_end;
    logic [3:0]  status;
    logic [15:0] close_code;
    int          fail_count;
    int          pending;

    int          cycles = 0;
    int          stall_left = 0;
    int          bytes_sent = 0;
    logic        took = 1'b0;
    logic        quiet = 1'b0;
    logic        role_now = 1'b0;
    logic        deflate_now = 1'b0;
    logic        msg_open = 1'b0;
    logic        msg_text = 1'b0;
    logic        msg_packed = 1'b0;

    websocket_rx_deframer_top i_dut (.*);

    websocket_rx_deframer_checker i_checker (.*);

    // clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("websocket_rx_deframer_top regression: fail");
            $finish;
        end
    end

    // result side stall pattern
    always @(posedge clk)
        took <= out_valid && !out_stall;

    always @(negedge clk)
    begin
        int n_wait;
        n_wait = took ? (quiet ? 0 : $urandom_range(0, 12)) : stall_left;
        if (n_wait > 0)
        begin
            out_stall <= 1'b1;
            stall_left <= n_wait - 1;
        end
        else
        begin
            out_stall <= 1'b0;
            stall_left <= 0;
        end
    end

    // one request on the byte channel, with a random gap before it
    task automatic push_byte(input logic [7:0] b);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 12);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        rx_byte <= b;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        bytes_sent++;
        @(negedge clk);
    endtask

    // build and send one frame; len_form 0 short, 1 16-bit, 2 64-bit
    task automatic send_frame(input logic fin, input logic [2:0] rsv, input logic [3:0] op,
                              input logic mask_on, input int len_form,
                              input logic [7:0] body[$]);
        logic [31:0] mkey;
        logic [63:0] n;
        n = 64'(body.size());
        mkey = $urandom;
        push_byte({fin, rsv, op});
        if (len_form == 0 && n <= 125)
        begin
            push_byte({mask_on, n[6:0]});
        end
        else if (len_form == 1)
        begin
            push_byte({mask_on, 7'd126});
            push_byte(n[15:8]);
            push_byte(n[7:0]);
        end
        else
        begin
            push_byte({mask_on, 7'd127});
            for (int i = 7; i >= 0; i--) push_byte(n[8 * i +: 8]);
        end
        if (mask_on)
            for (int i = 3; i >= 0; i--) push_byte(mkey[8 * i +: 8]);
        for (int i = 0; i < body.size(); i++)
            push_byte(body[i] ^ (mask_on ? mkey[8 * (3 - i % 4) +: 8] : 8'd0));
    endtask

    // append one well-formed utf-8 character
    task automatic add_char(inout logic [7:0] body[$]);
        case ($urandom_range(0, 8))
            0, 1: body.push_back(8'($urandom_range(0, 8'h7F)));
            2:
            begin
                body.push_back(8'($urandom_range(8'hC2, 8'hDF)));
                body.push_back(8'($urandom_range(8'h80, 8'hBF)));
            end
            3:
            begin
                body.push_back(8'hE0);
                body.push_back(8'($urandom_range(8'hA0, 8'hBF)));
                body.push_back(8'($urandom_range(8'h80, 8'hBF)));
            end
            4:
            begin
                body.push_back(8'hED);
                body.push_back(8'($urandom_range(8'h80, 8'h9F)));
                body.push_back(8'($urandom_range(8'h80, 8'hBF)));
            end
            5:
            begin
                body.push_back($urandom_range(0, 1) ? 8'($urandom_range(8'hE1, 8'hEC))
                                                    : 8'($urandom_range(8'hEE, 8'hEF)));
                body.push_back(8'($urandom_range(8'h80, 8'hBF)));
                body.push_back(8'($urandom_range(8'h80, 8'hBF)));
            end
            6:
            begin
                body.push_back(8'hF0);
                body.push_back(8'($urandom_range(8'h90, 8'hBF)));
                repeat (2) body.push_back(8'($urandom_range(8'h80, 8'hBF)));
            end
            7:
            begin
                body.push_back(8'($urandom_range(8'hF1, 8'hF3)));
                repeat (3) body.push_back(8'($urandom_range(8'h80, 8'hBF)));
            end
            default:
            begin
                body.push_back(8'hF4);
                body.push_back(8'($urandom_range(8'h80, 8'h8F)));
                repeat (2) body.push_back(8'($urandom_range(8'h80, 8'hBF)));
            end
        endcase
    endtask

    task automatic fill_body(inout logic [7:0] body[$], input logic as_text, input int n);
        while (body.size() < n)
            if (as_text) add_char(body);
            else body.push_back(8'($urandom));
    endtask

    // one well-formed frame that keeps fragmentation legal
    task automatic random_frame();
        logic [7:0] body[$];
        logic [3:0] op;
        logic       fin;
        logic       rsv1;
        int         n;
        int         form;
        int         pick;
        if ($urandom_range(0, 9) == 0) quiet = ~quiet;
        pick = $urandom_range(0, 29);
        form = (pick == 0) ? 2 : (pick < 3) ? 1 : 0;
        n = (form == 1) ? $urandom_range(0, 200) : (form == 2) ? $urandom_range(0, 40)
                                                          : $urandom_range(0, 16);
        rsv1 = 1'b0;
        fin = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 3) == 0)
        begin
            // ping or pong, allowed in the middle of a message
            op = $urandom_range(0, 1) ? OP_PING : OP_PONG;
            fill_body(body, 1'b0, $urandom_range(0, 10));
            send_frame(1'b1, 3'b000, op, !role_now, 0, body);
            return;
        end
        if (msg_open)
        begin
            op = OP_CONT;
        end
        else
        begin
            op = $urandom_range(0, 1) ? OP_TEXT : OP_BIN;
            rsv1 = deflate_now && $urandom_range(0, 1);
            msg_text = (op == OP_TEXT);
            msg_packed = rsv1;
        end
        fill_body(body, msg_text && !msg_packed, n);
        send_frame(fin, {rsv1, 2'b00}, op, !role_now, form, body);
        msg_open = !fin;
    endtask

    // idle the block and write both registers
    task automatic set_mode(input logic role, input logic deflate);
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (8) @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= REG_ROLE[0];
        cfg_wdata <= role;
        @(negedge clk);
        cfg_index <= REG_DEFLATE[0];
        cfg_wdata <= deflate;
        @(negedge clk);
        cfg_we <= 1'b0;
        role_now = role;
        deflate_now = deflate;
    endtask

    // the stream ends with a close, one protocol error or one utf-8 error
    task automatic final_frame();
        logic [7:0] body[$];
        logic [3:0] op;
        logic [15:0] code;
        int kind;
        kind = $urandom_range(0, 10);
        if (msg_open && kind != 9)
        begin
            send_frame(1'b1, 3'b000, OP_CONT, !role_now, 0, body);
            msg_open = 1'b0;
        end
        case (kind)
            0: send_frame(1'b1, 3'b000, OP_CLOSE, !role_now, 0, body);
            1:
            begin
                body.push_back(8'($urandom));
                send_frame(1'b1, 3'b000, OP_CLOSE, !role_now, 0, body);
            end
            2, 3:
            begin
                case ($urandom_range(0, 5))
                    0: code = 16'd1000;
                    1: code = 16'd1003;
                    2: code = 16'd1011;
                    3: code = 16'd3000;
                    4: code = 16'd4999;
                    default: code = 16'($urandom);
                endcase
                if (kind == 3) code = $urandom_range(0, 1) ? 16'd1005 : 16'd5000;
                body.push_back(code[15:8]);
                body.push_back(code[7:0]);
                fill_body(body, 1'b0, $urandom_range(2, 6));
                send_frame(1'b1, 3'b000, OP_CLOSE, !role_now, 0, body);
            end
            4: send_frame(1'b1, 3'($urandom_range(1, 3)), OP_TEXT, !role_now, 0, body);
            5: send_frame(1'b1, 3'b100, OP_PING, !role_now, 0, body);
            6:
            begin
                op = $urandom_range(0, 1) ? 4'($urandom_range(3, 7))
                                          : 4'($urandom_range(11, 15));
                send_frame(1'b1, 3'b000, op, !role_now, 0, body);
            end
            7: send_frame(1'b1, 3'b000, OP_BIN, role_now, 0, body);
            8: send_frame(1'b1, 3'b000, OP_CONT, !role_now, 0, body);
            9:
            begin
                if (!msg_open)
                begin
                    body.push_back(8'($urandom));
                    send_frame(1'b0, 3'b000, OP_BIN, !role_now, 0, body);
                end
                send_frame(1'b1, 3'b000, OP_TEXT, !role_now, 0, body);
            end
            default:
            begin
                fill_body(body, 1'b1, 3);
                if ($urandom_range(0, 1)) body.push_back($urandom_range(0, 1) ? 8'hFF : 8'hC0);
                else body.push_back(8'hE2);
                send_frame(1'b1, 3'b000, OP_TEXT, !role_now, 0, body);
            end
        endcase
        // bytes after the stream stopped
        repeat (20) push_byte(8'($urandom));
    endtask

    // stimulus
    initial
    begin
        logic [7:0] body[$];
        logic [1:0] mode;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // extremes: empty frames, 0x00 and 0xff bytes, edge utf-8 forms
        set_mode(1'b0, 1'b0);
        send_frame(1'b1, 3'b000, OP_TEXT, 1'b1, 0, body);
        body = '{8'h00, 8'hFF, 8'h55, 8'hAA};
        send_frame(1'b0, 3'b000, OP_BIN, 1'b1, 0, body);
        send_frame(1'b1, 3'b000, OP_PING, 1'b1, 0, body);
        body = '{8'h80};
        send_frame(1'b1, 3'b000, OP_CONT, 1'b1, 0, body);
        body = '{8'hF0, 8'h90, 8'h80, 8'h80, 8'hF4, 8'h8F, 8'hBF, 8'hBF, 8'hED, 8'h9F,
                 8'hBF, 8'hE0, 8'hA0, 8'h80, 8'h7F, 8'hC2, 8'h80};
        send_frame(1'b1, 3'b000, OP_TEXT, 1'b1, 1, body);

        // random frames through every setting of the registers
        for (int p = 0; p < 4; p++)
        begin
            mode = (p == 0) ? 2'b11 : (p == 1) ? 2'b01 : (p == 2) ? 2'b10 : 2'b00;
            set_mode(mode[1], mode[0]);
            while (bytes_sent < BYTE_TARGET * (p + 1) / 4) random_frame();
        end
        final_frame();
        in_valid <= 1'b0;

        while (pending != 0) @(negedge clk);
        repeat (10) @(negedge clk);
        if (fail_count == 0)
            $display("websocket_rx_deframer_top regression: pass");
        else
            $display("websocket_rx_deframer_top regression: fail");
        $finish;
    end

endmodule

>>> filelist.f
src/wsrx_pkg.sv
src/wsrx_front.sv
src/wsrx_queue.sv
src/wsrx_back.sv
src/websocket_rx_deframer_top.sv
sim/websocket_rx_deframer_checker.sv
sim/tb_websocket_rx_deframer_top.sv
